FILE: rtl/lgfp_pkg.sv
// Package for the LED grayscale frame packer: request/result structs,
// function codes, state encoding and size constants. No dependencies.
package lgfp_pkg;

	localparam int CHANNELS_DEF = 16;
	localparam int LEVEL_W      = 16;
	localparam int GS_BITS      = 12;
	localparam int DIGIT_W      = 4;

	typedef enum logic [1:0] {
		FN_WRITE = 2'd0,
		FN_SET   = 2'd1,
		FN_ADD   = 2'd2,
		FN_SEND  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADD,
		ST_SEND,
		ST_PAD
	} state_t;

	typedef struct packed {
		func_t                func;
		logic                 eye_sel;
		logic [3:0]           channel;
		logic [LEVEL_W-1:0]   level;
	} request_t;

	typedef struct packed {
		logic [LEVEL_W-1:0]   word;
		logic                 from_right;
		logic                 last;
	} result_t;

endpackage

FILE: rtl/led_grayscale_frame_packer.sv
// LED grayscale frame packer: two banks of levels, write/set/add commands
// and a 4-bit-digit serial packer producing 16-bit frame words. Uses lgfp_pkg.
// Write and set-all act on acceptance; add-all steps through the channels (one entry of
// each bank per cycle through a single adder per bank). Send shifts out 12 bits per
// channel, 4 per cycle, plus up to 3 zero-pad digits per bank; each word leaves the
// output register in the cycle after its last digit. The receiver cannot stall.
// Reset clears both banks to zero.
module led_grayscale_frame_packer
	import lgfp_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  request_t request,
	output logic     result_valid,
	output result_t  result
);

	localparam int CW = $clog2(CHANNELS);
	localparam logic [CW-1:0] LAST_CH = CW'(CHANNELS - 1);

	state_t state_q, state_d;

	logic [LEVEL_W-1:0] left_q  [CHANNELS];
	logic [LEVEL_W-1:0] right_q [CHANNELS];

	logic [CW-1:0]        ch_q;
	logic [1:0]           dig_q;
	logic [1:0]           wcnt_q;
	logic                 eye_q;
	logic [LEVEL_W-1:0]   addend_q;
	logic [7:0]           sr_q;
	logic [LEVEL_W-1:0]   wacc_q;
	logic                 out_valid_q;
	result_t              out_q;

	logic                 accept;
	logic [LEVEL_W-1:0]   cur_lv;
	logic [LEVEL_W-1:0]   mag;
	logic [GS_BITS-1:0]   cur_gs;
	logic [DIGIT_W-1:0]   digit;
	logic [LEVEL_W-1:0]   wnext;
	logic                 eye_end;
	logic                 emit;
	logic                 eye_done;
	logic                 last_word;
	logic                 wr_hit;
	logic [CW-1:0]        wr_idx;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	assign cur_lv = eye_q ? right_q[ch_q] : left_q[ch_q];
	// magnitude of the two's complement level; 0x8000 keeps 0x8000
	assign mag    = cur_lv[LEVEL_W-1] ? (LEVEL_W'(0) - cur_lv) : cur_lv;
	assign cur_gs = mag[GS_BITS-1:0];
	assign digit  = (dig_q == 2'd0) ? cur_gs[GS_BITS-1 -: DIGIT_W] : sr_q[7:4];
	assign wnext  = {wacc_q[LEVEL_W-DIGIT_W-1:0],
		(state_q == ST_PAD) ? DIGIT_W'(0) : digit};
	assign eye_end = (ch_q == LAST_CH) && (dig_q == 2'd2);

	assign wr_hit = (32'(request.channel) < 32'(CHANNELS));
	assign wr_idx = CW'(request.channel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		emit      = 1'b0;
		eye_done  = 1'b0;
		last_word = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (request.func)
						FN_ADD:  state_d = ST_ADD;
						FN_SEND: state_d = ST_SEND;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD: begin
				if (ch_q == LAST_CH) begin
					state_d = ST_IDLE;
				end
			end
			ST_SEND: begin
				emit = (wcnt_q == 2'd3);
				if (eye_end) begin
					if (wcnt_q == 2'd3) begin
						eye_done  = 1'b1;
						last_word = eye_q;
						if (eye_q) begin
							state_d = ST_IDLE;
						end
					end else begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				// zero digits fill the tail of a bank's final word
				emit = (wcnt_q == 2'd3);
				if (wcnt_q == 2'd3) begin
					eye_done  = 1'b1;
					last_word = eye_q;
					state_d   = eye_q ? ST_IDLE : ST_SEND;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				left_q[i]  <= '0;
				right_q[i] <= '0;
			end
			ch_q        <= '0;
			dig_q       <= '0;
			wcnt_q      <= '0;
			eye_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= emit;
			if (accept) begin
				ch_q   <= '0;
				dig_q  <= '0;
				wcnt_q <= '0;
				eye_q  <= 1'b0;
				case (request.func)
					FN_WRITE: begin
						if (wr_hit) begin
							if (request.eye_sel) begin
								right_q[wr_idx] <= request.level;
							end else begin
								left_q[wr_idx] <= request.level;
							end
						end
					end
					FN_SET: begin
						for (int i = 0; i < CHANNELS; i++) begin
							left_q[i]  <= request.level;
							right_q[i] <= request.level;
						end
					end
					default: ;
				endcase
			end
			case (state_q)
				ST_ADD: begin
					left_q[ch_q]  <= left_q[ch_q] + addend_q;
					right_q[ch_q] <= right_q[ch_q] + addend_q;
					ch_q <= (ch_q == LAST_CH) ? '0 : ch_q + 1'b1;
				end
				ST_SEND: begin
					wcnt_q <= wcnt_q + 1'b1;
					if (dig_q == 2'd2) begin
						dig_q <= '0;
						ch_q  <= (ch_q == LAST_CH) ? '0 : ch_q + 1'b1;
					end else begin
						dig_q <= dig_q + 1'b1;
					end
				end
				ST_PAD: begin
					wcnt_q <= wcnt_q + 1'b1;
				end
				default: ;
			endcase
			if (eye_done) begin
				eye_q <= ~eye_q;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			addend_q <= request.level;
		end
		if (state_q == ST_SEND) begin
			sr_q <= (dig_q == 2'd0) ? cur_gs[7:0] : {sr_q[3:0], DIGIT_W'(0)};
		end
		if (state_q == ST_SEND || state_q == ST_PAD) begin
			wacc_q <= wnext;
		end
		if (emit) begin
			out_q.word       <= wnext;
			out_q.from_right <= eye_q;
			out_q.last       <= last_word;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

FILE: tb/sv/led_grayscale_frame_packer_tb.sv
// Testbench for led_grayscale_frame_packer: directed and random requests, with
// a predictor of both level banks and the packed frame words. Uses lgfp_pkg.
module led_grayscale_frame_packer_tb;
	import lgfp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD = 10;
	localparam int N_CH        = CHANNELS_DEF;
	localparam int N_WORDS     = (N_CH * GS_BITS + 15) / 16;
	localparam int STREAM_W    = N_WORDS * 16;
	localparam int N_RANDOM    = 100;
	localparam int DRAIN_WAIT  = 200;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		request_t req;
		int       idle_pct;
	} pending_req_t;

	logic     clk    = 1'b0;
	logic     arst_n = 1'b0;
	logic     start  = 1'b0;
	request_t request = '0;
	logic     busy;
	logic     result_valid;
	result_t  result;

	pending_req_t pending_reqs[$];
	result_t      frame_words[$];
	logic [LEVEL_W-1:0] left_bank  [N_CH];
	logic [LEVEL_W-1:0] right_bank [N_CH];

	int n_total    = 0;
	int n_accepted = 0;
	int n_errors   = 0;
	int n_cycles   = 0;

	led_grayscale_frame_packer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result)
	);

	always #HALF_PERIOD clk = ~clk;

	// magnitude of the level as two's complement, cut to the grayscale width
	function automatic logic [GS_BITS-1:0] channel_intensity(logic [LEVEL_W-1:0] lv);
		logic [LEVEL_W-1:0] mag;
		mag = lv[LEVEL_W-1] ? -lv : lv;
		return mag[GS_BITS-1:0];
	endfunction

	task automatic apply_command(input request_t r);
		logic [STREAM_W-1:0] stream;
		result_t             w;
		case (r.func)
		FN_WRITE: begin
			if (r.channel < N_CH) begin
				if (r.eye_sel)
					right_bank[r.channel] = r.level;
				else
					left_bank[r.channel] = r.level;
			end
		end
		FN_SET: begin
			for (int i = 0; i < N_CH; i++) begin
				left_bank[i]  = r.level;
				right_bank[i] = r.level;
			end
		end
		FN_ADD: begin
			for (int i = 0; i < N_CH; i++) begin
				left_bank[i]  = left_bank[i] + r.level;
				right_bank[i] = right_bank[i] + r.level;
			end
		end
		default: begin
			for (int e = 0; e < 2; e++) begin
				stream = '0;
				for (int ch = 0; ch < N_CH; ch++)
					stream[STREAM_W-1-GS_BITS*ch -: GS_BITS] =
						channel_intensity(e ? right_bank[ch] : left_bank[ch]);
				for (int wd = 0; wd < N_WORDS; wd++) begin
					w.word       = stream[STREAM_W-1-16*wd -: 16];
					w.from_right = (e == 1);
					w.last       = (e == 1) && (wd == N_WORDS - 1);
					frame_words.push_back(w);
				end
			end
		end
		endcase
	endtask

	task automatic queue_request(input func_t f, input logic eye, input logic [3:0] ch,
			input logic [LEVEL_W-1:0] lv);
		pending_req_t p;
		p.req.func    = f;
		p.req.eye_sel = eye;
		p.req.channel = ch;
		p.req.level   = lv;
		p.idle_pct    = 0;
		pending_reqs.push_back(p);
	endtask

	function automatic logic [LEVEL_W-1:0] pick_level();
		case ($urandom_range(9))
		0:       return 16'h0000;
		1:       return 16'hFFFF;
		2:       return 16'h8000;
		3:       return 16'h7FFF;
		4:       return 16'h0FFF;
		5:       return 16'hF001;
		default: return LEVEL_W'($urandom);
		endcase
	endfunction

	// sender: holds a request until accepted, then either idles or offers the next
	always @(posedge clk) begin : drive_requests
		pending_req_t nxt;
		if (arst_n) begin
			if (start && !busy) begin
				apply_command(request);
				n_accepted++;
			end
			if (start && busy) begin
				// request still waiting
			end else if (pending_reqs.size() != 0 &&
					$urandom_range(99) >= pending_reqs[0].idle_pct) begin
				nxt = pending_reqs.pop_front();
				start   <= 1'b1;
				request <= nxt.req;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_words
		result_t exp_w;
		if (arst_n && result_valid) begin
			if (frame_words.size() == 0) begin
				$display("%0t: unexpected word: actual %h/%b/%b",
					$time, result.word, result.from_right, result.last);
				n_errors++;
			end else begin
				exp_w = frame_words.pop_front();
				if (result !== exp_w) begin
					$display("%0t: mismatch: expected %h/%b/%b, actual %h/%b/%b",
						$time, exp_w.word, exp_w.from_right, exp_w.last,
						result.word, result.from_right, result.last);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int r;
		for (int i = 0; i < N_CH; i++) begin
			left_bank[i]  = '0;
			right_bank[i] = '0;
		end

		// directed: send from reset, range extremes, most negative level, wraps
		queue_request(FN_SEND, 1'b0, 4'h0, 16'h0000);
		queue_request(FN_WRITE, 1'b0, 4'h0, 16'hFFFF);
		queue_request(FN_WRITE, 1'b1, 4'hF, 16'h8000);
		queue_request(FN_WRITE, 1'b0, 4'hF, 16'h7FFF);
		queue_request(FN_WRITE, 1'b1, 4'h0, 16'h0FFF);
		queue_request(FN_WRITE, 1'b0, 4'h7, 16'h1000);
		queue_request(FN_WRITE, 1'b1, 4'h8, 16'h8001);
		queue_request(FN_SEND, 1'b1, 4'hF, 16'hFFFF);
		queue_request(FN_SET, 1'b1, 4'hF, 16'h0ABC);
		queue_request(FN_SEND, 1'b0, 4'h5, 16'h5555);
		queue_request(FN_ADD, 1'b1, 4'hA, 16'hFFFF);
		queue_request(FN_SEND, 1'b0, 4'h0, 16'h0000);
		queue_request(FN_SET, 1'b0, 4'h0, 16'h8000);
		queue_request(FN_SEND, 1'b1, 4'h3, 16'hAAAA);
		queue_request(FN_ADD, 1'b0, 4'h0, 16'h8000);
		queue_request(FN_WRITE, 1'b1, 4'h5, 16'hF00F);
		queue_request(FN_SEND, 1'b0, 4'hC, 16'h1234);
		queue_request(FN_SET, 1'b0, 4'h0, 16'hFFFF);
		queue_request(FN_ADD, 1'b1, 4'hF, 16'h0001);
		queue_request(FN_SEND, 1'b1, 4'hF, 16'hFFFF);

		// random: mostly writes with frequent sends so frames carry mixed data
		for (int i = 0; i < N_RANDOM; i++) begin
			r = $urandom_range(99);
			if (r < 50)
				queue_request(FN_WRITE, 1'($urandom), 4'($urandom), pick_level());
			else if (r < 60)
				queue_request(FN_SET, 1'($urandom), 4'($urandom), pick_level());
			else if (r < 75)
				queue_request(FN_ADD, 1'($urandom), 4'($urandom), pick_level());
			else
				queue_request(FN_SEND, 1'($urandom), 4'($urandom), LEVEL_W'($urandom));
		end
		queue_request(FN_SEND, 1'b0, 4'h0, 16'h0000);

		// sender idling: light, then heavy, then none
		n_total = pending_reqs.size();
		for (int i = 0; i < n_total; i++)
			pending_reqs[i].idle_pct = (i < n_total / 3) ? 18 : (i < 2 * n_total / 3) ? 62 : 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (n_accepted < n_total)
			@(posedge clk);
		while (frame_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (n_errors == 0 && frame_words.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: files.f
rtl/lgfp_pkg.sv
rtl/led_grayscale_frame_packer.sv
tb/sv/led_grayscale_frame_packer_tb.sv
